[hdl/psq_pkg.sv]
// Shared types and constants for the positional sequence store.
`default_nettype none

package psq_pkg;

  localparam int DATA_W    = 32;
  localparam int OP_W      = 3;
  localparam int POS_W     = 8;
  localparam int OUT_CNT_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND      = 3'd0,
    OP_REMOVE_LAST = 3'd1,
    OP_INSERT      = 3'd2,
    OP_DELETE      = 3'd3,
    OP_DUMP        = 3'd4
  } opcode_t;

  // What a storage cell does at the next clock edge.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT,
    CELL_FROM_HEAD
  } cell_cmd_t;

endpackage

`default_nettype wire

[hdl/psq_if.sv]
// Valid/ready channel interfaces for the operation input and the result output.
`default_nettype none

interface psq_in_if;
  logic                                valid;
  logic                                ready;
  logic [psq_pkg::OP_W-1:0]            opcode;
  logic signed [psq_pkg::DATA_W-1:0]   item_value;
  logic [psq_pkg::POS_W-1:0]           position;

  modport source (output valid, output opcode, output item_value, output position,
                  input ready);
  modport sink   (input valid, input opcode, input item_value, input position,
                  output ready);
endinterface

interface psq_out_if;
  logic                                valid;
  logic                                ready;
  logic                                ok;
  logic signed [psq_pkg::DATA_W-1:0]   element;
  logic                                last;
  logic [psq_pkg::OUT_CNT_W-1:0]       count;

  modport source (output valid, output ok, output element, output last, output count,
                  input ready);
  modport sink   (input valid, input ok, input element, input last, input count,
                  output ready);
endinterface

`default_nettype wire

[hdl/positional_sequence_store_unit.sv]
// Top level of the positional sequence store: control, counters and the cell chain.
`default_nettype none

// Keeps an ordered list of up to CAPACITY signed 32-bit values in a chain of cells,
// one element per cell, with element 0 in the first cell. Append, remove-last, insert
// and delete each finish with one chain update: the cells shift towards or away from the head in a
// single step, and the single result beat sits in the output register on the next cycle.
// A dump of n elements rotates the chain one place per cycle while the output register is
// free, delivering the head cell as a result beat each time; after n rotations the list is
// back in its original order. A new operation is accepted only when no dump is running and
// the output register is empty or being emptied, so the rate is set by the output register
// and, for dumps, by the chain rotation; a dump of an empty list gives one failed beat.
module positional_sequence_store_unit #(
  parameter int CAPACITY = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  psq_in_if.sink    in_ch,
  psq_out_if.source out_ch
);
  import psq_pkg::*;

  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int CMP_W = POS_W + 1;

  typedef enum logic {ST_IDLE, ST_DUMP} state_t;

  state_t                   state_r;
  logic [CW-1:0]            cnt_r;
  logic [CW-1:0]            dump_idx_r;
  logic                     out_valid_r;
  logic                     out_ok_r;
  logic signed [DATA_W-1:0] out_element_r;
  logic                     out_last_r;
  logic [OUT_CNT_W-1:0]     out_count_r;

  logic                     out_free;
  logic                     accept;
  logic                     dump_step;
  logic                     full;
  logic                     empty;
  logic [CMP_W-1:0]         pos_ext;
  logic [CMP_W-1:0]         cnt_ext;
  logic                     app_ok;
  logic                     rem_ok;
  logic                     ins_ok;
  logic                     del_ok;
  logic                     op_ok;
  logic [CW-1:0]            cnt_nxt;
  logic                     dump_last;

  cell_cmd_t                cell_cmd  [CAPACITY];
  logic signed [DATA_W-1:0] cell_data [CAPACITY];

  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && out_free;
  assign accept    = in_ch.valid && in_ch.ready;
  assign dump_step = (state_r == ST_DUMP) && out_free;

  assign full    = (cnt_r == CW'(CAPACITY));
  assign empty   = (cnt_r == '0);
  assign pos_ext = CMP_W'(in_ch.position);
  assign cnt_ext = CMP_W'(cnt_r);
  assign app_ok  = !full;
  assign rem_ok  = !empty;
  assign ins_ok  = !full && (pos_ext <= cnt_ext);
  assign del_ok  = (in_ch.position != '0) && (pos_ext <= cnt_ext);
  assign dump_last = ((dump_idx_r + CW'(1)) == cnt_r);

  always_comb begin
    op_ok   = 1'b0;
    cnt_nxt = cnt_r;
    unique case (in_ch.opcode)
      OP_APPEND: begin
        op_ok = app_ok;
        if (app_ok) cnt_nxt = cnt_r + CW'(1);
      end
      OP_REMOVE_LAST: begin
        op_ok = rem_ok;
        if (rem_ok) cnt_nxt = cnt_r - CW'(1);
      end
      OP_INSERT: begin
        op_ok = ins_ok;
        if (ins_ok) cnt_nxt = cnt_r + CW'(1);
      end
      OP_DELETE: begin
        op_ok = del_ok;
        if (del_ok) cnt_nxt = cnt_r - CW'(1);
      end
      default: begin
        op_ok   = 1'b0;
        cnt_nxt = cnt_r;
      end
    endcase
  end

  // Each cell decides its move from its own place in the chain.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CMP_W-1:0] IDX  = CMP_W'(i);
    localparam logic [CMP_W-1:0] IDX1 = CMP_W'(i + 1);

    logic signed [DATA_W-1:0] left_value;
    logic signed [DATA_W-1:0] right_value;

    always_comb begin
      cell_cmd[i] = CELL_HOLD;
      if (accept) begin
        unique case (in_ch.opcode)
          OP_APPEND: begin
            if (app_ok && (IDX == cnt_ext)) cell_cmd[i] = CELL_LOAD;
          end
          OP_INSERT: begin
            if (ins_ok) begin
              if (IDX == pos_ext) begin
                cell_cmd[i] = CELL_LOAD;
              end else if ((IDX > pos_ext) && (IDX <= cnt_ext)) begin
                cell_cmd[i] = CELL_FROM_LEFT;
              end
            end
          end
          OP_DELETE: begin
            if (del_ok && (IDX1 >= pos_ext) && (IDX1 < cnt_ext)) begin
              cell_cmd[i] = CELL_FROM_RIGHT;
            end
          end
          default: cell_cmd[i] = CELL_HOLD;
        endcase
      end else if (dump_step) begin
        // Rotate the occupied part of the chain: the head wraps round to the tail.
        if (IDX1 < cnt_ext) begin
          cell_cmd[i] = CELL_FROM_RIGHT;
        end else if (IDX1 == cnt_ext) begin
          cell_cmd[i] = CELL_FROM_HEAD;
        end
      end
    end

    if (i == 0) begin : g_head
      assign left_value = in_ch.item_value;
    end else begin : g_body
      assign left_value = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_value = cell_data[0];
    end else begin : g_inner
      assign right_value = cell_data[i+1];
    end

    psq_cell u_cell (
      .clk         (clk),
      .cmd         (cell_cmd[i]),
      .load_value  (in_ch.item_value),
      .left_value  (left_value),
      .right_value (right_value),
      .head_value  (cell_data[0]),
      .data        (cell_data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      dump_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        cnt_r <= cnt_nxt;
        if ((in_ch.opcode == OP_DUMP) && !empty) begin
          state_r     <= ST_DUMP;
          dump_idx_r  <= '0;
          out_valid_r <= 1'b0;
        end else begin
          out_valid_r   <= 1'b1;
          out_ok_r      <= op_ok;
          out_element_r <= '0;
          out_last_r    <= 1'b1;
          out_count_r   <= OUT_CNT_W'(cnt_nxt);
        end
      end else if (dump_step) begin
        out_valid_r   <= 1'b1;
        out_ok_r      <= 1'b1;
        out_element_r <= cell_data[0];
        out_last_r    <= dump_last;
        out_count_r   <= OUT_CNT_W'(cnt_r);
        dump_idx_r    <= dump_idx_r + CW'(1);
        if (dump_last) state_r <= ST_IDLE;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.ok      = out_ok_r;
  assign out_ch.element = out_element_r;
  assign out_ch.last    = out_last_r;
  assign out_ch.count   = out_count_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("element count exceeds capacity");

  a_dump_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DUMP) |-> (dump_idx_r < cnt_r))
    else $error("dump index ran past the element count");

  a_cnt_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(cnt_r))
    else $error("element count changed without an accepted beat");

  a_update_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_ch.opcode != OP_DUMP)) |=> (out_valid_r && out_last_r))
    else $error("update beat did not produce a final result");

  a_dump_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DUMP) |-> !accept)
    else $error("operation accepted during a dump");

endmodule

`default_nettype wire

[hdl/psq_cell.sv]
// One storage cell of the sequence chain: holds one element and can take a neighbour's.
`default_nettype none

module psq_cell (
  input  wire logic                              clk,
  input  wire psq_pkg::cell_cmd_t                cmd,
  input  wire logic signed [psq_pkg::DATA_W-1:0] load_value,
  input  wire logic signed [psq_pkg::DATA_W-1:0] left_value,
  input  wire logic signed [psq_pkg::DATA_W-1:0] right_value,
  input  wire logic signed [psq_pkg::DATA_W-1:0] head_value,
  output logic signed [psq_pkg::DATA_W-1:0]      data
);
  import psq_pkg::*;

  logic signed [DATA_W-1:0] data_r;

  always_ff @(posedge clk) begin
    unique case (cmd)
      CELL_LOAD:       data_r <= load_value;
      CELL_FROM_LEFT:  data_r <= left_value;
      CELL_FROM_RIGHT: data_r <= right_value;
      CELL_FROM_HEAD:  data_r <= head_value;
      default:         data_r <= data_r;
    endcase
  end

  assign data = data_r;

endmodule

`default_nettype wire

[tb/sv/psq_list_monitor.sv]
// Channel monitor that mirrors the stored list and checks every result beat against it.
`timescale 1ns / 1ps

module psq_list_monitor #(
  parameter int CAPACITY = 16
) (
  input  logic clk,
  input  logic rst_n,
  psq_in_if    in_ch,
  psq_out_if   out_ch,
  output int   error_count,
  output int   results_due
);
  import psq_pkg::*;

  localparam int REPORT_LIMIT = 40;

  typedef struct packed {
    logic                 ok;
    logic [DATA_W-1:0]    element;
    logic                 last;
    logic [OUT_CNT_W-1:0] count;
  } result_beat_t;

  logic signed [DATA_W-1:0] mirror_list[$];
  result_beat_t             pending_results[$];

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                 logic [DATA_W-1:0] want);
    if (error_count < REPORT_LIMIT) begin
      $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
    end
    error_count++;
  endtask

  // The count field always reflects the list length after the operation.
  function automatic result_beat_t make_beat(logic ok, logic [DATA_W-1:0] element,
                                             logic last);
    result_beat_t beat;
    beat.ok      = ok;
    beat.element = element;
    beat.last    = last;
    beat.count   = OUT_CNT_W'(mirror_list.size());
    return beat;
  endfunction

  task automatic apply_list_op(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] value,
                               logic [POS_W-1:0] pos);
    int   fill;
    logic ok;
    fill = mirror_list.size();
    ok   = 1'b0;
    case (op)
      OP_APPEND: begin
        if (fill < CAPACITY) begin
          mirror_list.push_back(value);
          ok = 1'b1;
        end
      end
      OP_REMOVE_LAST: begin
        if (fill > 0) begin
          mirror_list.delete(fill - 1);
          ok = 1'b1;
        end
      end
      OP_INSERT: begin
        if (fill < CAPACITY && int'(pos) <= fill) begin
          mirror_list.insert(int'(pos), value);
          ok = 1'b1;
        end
      end
      OP_DELETE: begin
        if (pos != '0 && int'(pos) <= fill) begin
          mirror_list.delete(int'(pos) - 1);
          ok = 1'b1;
        end
      end
      OP_DUMP: begin
        if (fill == 0) begin
          pending_results.push_back(make_beat(1'b0, '0, 1'b1));
        end
        for (int i = 0; i < fill; i++) begin
          pending_results.push_back(make_beat(1'b1, mirror_list[i], i == fill - 1));
        end
      end
      default: ;
    endcase
    // Every operation other than a dump, unused codes included, gives one beat.
    if (op != OP_DUMP) begin
      pending_results.push_back(make_beat(ok, '0, 1'b1));
    end
  endtask

  task automatic check_result(logic ok, logic [DATA_W-1:0] element, logic last,
                              logic [OUT_CNT_W-1:0] count);
    result_beat_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result beat with nothing expected", element, '0);
    end else begin
      want = pending_results.pop_front();
      if (ok !== want.ok) report_mismatch("ok", DATA_W'(ok), DATA_W'(want.ok));
      if (element !== want.element) report_mismatch("element", element, want.element);
      if (last !== want.last) report_mismatch("last", DATA_W'(last), DATA_W'(want.last));
      if (count !== want.count) begin
        report_mismatch("count", DATA_W'(count), DATA_W'(want.count));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mirror_list.delete();
      pending_results.delete();
    end else begin
      // A result beat can never stem from an item accepted at the same edge.
      if (out_ch.valid && out_ch.ready) begin
        check_result(out_ch.ok, out_ch.element, out_ch.last, out_ch.count);
      end
      if (in_ch.valid && in_ch.ready) begin
        apply_list_op(in_ch.opcode, in_ch.item_value, in_ch.position);
      end
    end
    results_due = pending_results.size();
  end

endmodule

[tb/sv/positional_sequence_store_unit_test.sv]
// Test top for the positional sequence store: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module positional_sequence_store_unit_test;
  import psq_pkg::*;

  localparam int CAPACITY     = 16;
  localparam int RANDOM_ITEMS = 330;
  localparam int HOLD_CYCLES  = 250;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 20;

  localparam logic [OP_W-1:0]   OP_RESERVED_LO = 3'd5;
  localparam logic [OP_W-1:0]   OP_RESERVED_HI = 3'd7;
  localparam logic [DATA_W-1:0] VALUE_MAX      = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] VALUE_MIN      = 32'h8000_0000;

  logic clk          = 1'b0;
  logic rst_n        = 1'b0;
  bit   gapless      = 1'b0;
  bit   hold_request = 1'b0;
  bit   hold_done    = 1'b0;
  int   idle_cycles  = 0;
  int   error_count;
  int   results_due;

  psq_in_if  in_ch();
  psq_out_if out_ch();

  positional_sequence_store_unit #(.CAPACITY(CAPACITY)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  psq_list_monitor #(.CAPACITY(CAPACITY)) monitor (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .error_count(error_count),
    .results_due(results_due)
  );

  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one, none at all during a gapless stretch.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (gapless || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Bias 0 grows the list, 1 shrinks it, 2 mixes evenly.
  function automatic logic [OP_W-1:0] pick_op(int bias);
    int r;
    int a, b, c, d, e;
    r = $urandom_range(0, 99);
    case (bias)
      0:       begin a = 35; b = 70; c = 75; d = 85; e = 97; end
      1:       begin a = 10; b = 20; c = 50; d = 85; e = 97; end
      default: begin a = 20; b = 40; c = 55; d = 80; e = 95; end
    endcase
    if (r < a) return OP_APPEND;
    if (r < b) return OP_INSERT;
    if (r < c) return OP_REMOVE_LAST;
    if (r < d) return OP_DELETE;
    if (r < e) return OP_DUMP;
    return OP_W'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 19))
      0:       v = VALUE_MIN;
      1:       v = VALUE_MAX;
      2:       v = '0;
      3:       v = '1;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // Mostly near the live range so that inserts and deletes often succeed.
  function automatic logic [POS_W-1:0] pick_position();
    if ($urandom_range(0, 99) < 85) return POS_W'($urandom_range(0, CAPACITY + 1));
    return POS_W'($urandom_range(0, 255));
  endfunction

  // Offers one beat and returns at the edge that takes it, after an optional gap.
  task automatic send_beat(logic [OP_W-1:0] op, logic [DATA_W-1:0] value,
                           logic [POS_W-1:0] pos);
    int gap;
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.item_value <= value;
    in_ch.position   <= pos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    gap = gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // The monitor updates its count at the rising edge, so it is read at the falling one.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (results_due != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin : stimulus
    logic [OP_W-1:0] op;
    int              bias;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = OP_APPEND;
    in_ch.item_value = '0;
    in_ch.position   = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Failures on an empty list, the unused opcodes, and the first two elements added.
    send_beat(OP_DUMP, '0, '0);
    send_beat(OP_REMOVE_LAST, '1, '1);
    send_beat(OP_DELETE, '0, 8'd1);
    send_beat(OP_INSERT, VALUE_MAX, 8'd255);
    send_beat(OP_RESERVED_LO, '1, '1);
    send_beat(OP_INSERT, VALUE_MAX, 8'd0);
    send_beat(OP_APPEND, VALUE_MIN, '1);
    send_beat(OP_RESERVED_HI, VALUE_MIN, 8'd1);

    // Fill up, alternating between appends and inserts at the head and at the tail.
    for (int k = 2; k < CAPACITY; k++) begin
      case (k % 3)
        0:       send_beat(OP_APPEND, pick_value(), '0);
        1:       send_beat(OP_INSERT, pick_value(), 8'd0);
        default: send_beat(OP_INSERT, pick_value(), POS_W'(k));
      endcase
    end
    send_beat(OP_APPEND, '1, '0);
    send_beat(OP_INSERT, '1, 8'd0);
    send_beat(OP_DUMP, '0, '0);
    send_beat(OP_DELETE, '0, 8'd0);
    send_beat(OP_DELETE, '0, POS_W'(CAPACITY));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // The receiver stalls for a long while; the sender keeps offering beats.
      if (i == 100) hold_request <= 1'b1;
      if (i == 130) wait_drained();
      if (i == 200) gapless <= 1'b1;
      if (i == 260) gapless <= 1'b0;
      bias = (i / 40) % 3;
      op   = pick_op(bias);
      send_beat(op, pick_value(), pick_position());
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (error_count == 0 && results_due == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done <= 1'b1;
      end else begin
        stall = gap_len();
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  // Ends the run when no beat has moved on either channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
